FILE: design/bsf_pkg.sv
package bsf_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_RESULTS     = 4;
    localparam int SLOT_W          = $clog2(MAX_RESULTS);
    localparam int NUM_W           = $clog2(MAX_RESULTS + 1);

    // smallest receiver buffer that can hold start flag, one byte and end flag
    localparam logic [15:0] MIN_DEST = 16'd3;

    localparam logic [7:0]  START_FLAG_RST    = 8'd126;
    localparam logic [7:0]  END_FLAG_RST      = 8'd127;
    localparam logic [7:0]  ESCAPE_BYTE_RST   = 8'd125;
    localparam logic [7:0]  XOR_MASK_RST      = 8'd32;
    localparam logic [15:0] MAX_DATA_LEN_RST  = 16'd255;
    localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd255;
    localparam logic [15:0] DEST_SIZE_RST     = 16'd255;

    typedef enum logic [2:0] {
        REG_START_FLAG    = 3'd0,
        REG_END_FLAG      = 3'd1,
        REG_ESCAPE_BYTE   = 3'd2,
        REG_XOR_MASK      = 3'd3,
        REG_MAX_DATA_LEN  = 3'd4,
        REG_MAX_FRAME_LEN = 3'd5,
        REG_DEST_SIZE     = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PARAM    = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_NO_MEM   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  start_flag;
        logic [7:0]  end_flag;
        logic [7:0]  escape_byte;
        logic [7:0]  xor_mask;
        logic [15:0] max_data_len;
        logic [15:0] max_frame_len;
        logic [15:0] dest_size;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        frame_done;
        status_t     status;
        logic [15:0] frame_length;
    } result_t;

endpackage

FILE: design/bsf_cfg_regs.sv
module bsf_cfg_regs
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    output bsf_pkg::cfg_t  cfg
);
    import bsf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_flag    <= START_FLAG_RST;
            cfg_reg.end_flag      <= END_FLAG_RST;
            cfg_reg.escape_byte   <= ESCAPE_BYTE_RST;
            cfg_reg.xor_mask      <= XOR_MASK_RST;
            cfg_reg.max_data_len  <= MAX_DATA_LEN_RST;
            cfg_reg.max_frame_len <= MAX_FRAME_LEN_RST;
            cfg_reg.dest_size     <= DEST_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_FLAG:    cfg_reg.start_flag    <= cfg_data[7:0];
                REG_END_FLAG:      cfg_reg.end_flag      <= cfg_data[7:0];
                REG_ESCAPE_BYTE:   cfg_reg.escape_byte   <= cfg_data[7:0];
                REG_XOR_MASK:      cfg_reg.xor_mask      <= cfg_data[7:0];
                REG_MAX_DATA_LEN:  cfg_reg.max_data_len  <= cfg_data;
                REG_MAX_FRAME_LEN: cfg_reg.max_frame_len <= cfg_data;
                REG_DEST_SIZE:     cfg_reg.dest_size     <= cfg_data;
                default:           ;  // drop writes to unmapped indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/bsf_encoder.sv
module bsf_encoder
#(
    parameter int COUNT_WIDTH = bsf_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsf_pkg::cfg_t               cfg,
    input  logic                        accept,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    output bsf_pkg::result_t            res [bsf_pkg::MAX_RESULTS],
    output logic [bsf_pkg::NUM_W-1:0]   res_num
);
    import bsf_pkg::*;

    localparam int CNT_W = COUNT_WIDTH + 1;
    localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

    logic             frame_open_reg;
    logic [CNT_W-1:0] raw_reg;
    logic [CNT_W-1:0] enc_reg;
    logic             perr_reg;
    logic             oerr_reg;

    logic             opening;
    logic [CNT_W-1:0] raw_base;
    logic [CNT_W-1:0] enc_base;
    logic [CNT_W:0]   raw_sum;
    logic [CNT_W:0]   enc_sum;
    logic [CNT_W:0]   len_sum;
    logic [CNT_W-1:0] raw_next;
    logic [CNT_W-1:0] enc_next;
    logic [CNT_W-1:0] len_cnt;
    logic [15:0]      len_out;
    logic             special;
    logic             perr_next;
    logic             oerr_next;
    status_t          code;

    assign opening  = !frame_open_reg;
    assign raw_base = opening ? '0 : raw_reg;
    assign enc_base = opening ? CNT_W'(1) : enc_reg;

    assign special = (data_byte == cfg.start_flag) || (data_byte == cfg.end_flag)
                  || (data_byte == cfg.escape_byte);

    // saturating counters: hold at all ones
    assign raw_sum  = {1'b0, raw_base} + (CNT_W+1)'(1);
    assign enc_sum  = {1'b0, enc_base} + (special ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    assign raw_next = raw_sum[CNT_W] ? '1 : raw_sum[CNT_W-1:0];
    assign enc_next = enc_sum[CNT_W] ? '1 : enc_sum[CNT_W-1:0];

    assign len_sum = {1'b0, enc_next} + (CNT_W+1)'(1);
    assign len_cnt = len_sum[CNT_W] ? '1 : len_sum[CNT_W-1:0];
    assign len_out = (CMP_W'(len_cnt) > CMP_W'(16'hFFFF)) ? 16'hFFFF : 16'(len_cnt);

    assign perr_next = (!opening && perr_reg) || (cfg.dest_size < MIN_DEST)
                    || (CMP_W'(raw_next) > CMP_W'(cfg.max_frame_len))
                    || (CMP_W'(raw_next) > CMP_W'(cfg.dest_size));
    assign oerr_next = (!opening && oerr_reg)
                    || (CMP_W'(enc_next) > CMP_W'(cfg.max_data_len));

    always_comb
    begin
        if (perr_next)
            code = ST_PARAM;
        else if (oerr_next)
            code = ST_TOO_LONG;
        else if (last_byte && (CMP_W'(enc_next) > CMP_W'(cfg.max_frame_len)))
            code = ST_TOO_LONG;
        else if (last_byte && (CMP_W'(enc_next) > CMP_W'(cfg.dest_size)))
            code = ST_NO_MEM;
        else
            code = ST_OK;
    end

    // pack the words of this item into consecutive slots
    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end
        res_num = '0;
        if (code == ST_OK)
        begin
            if (opening)
            begin
                res[res_num[SLOT_W-1:0]].out_byte   = cfg.start_flag;
                res[res_num[SLOT_W-1:0]].byte_valid = 1'b1;
                res_num = res_num + NUM_W'(1);
            end
            if (special)
            begin
                res[res_num[SLOT_W-1:0]].out_byte   = cfg.escape_byte;
                res[res_num[SLOT_W-1:0]].byte_valid = 1'b1;
                res_num = res_num + NUM_W'(1);
                res[res_num[SLOT_W-1:0]].out_byte   = data_byte ^ cfg.xor_mask;
                res[res_num[SLOT_W-1:0]].byte_valid = 1'b1;
                res_num = res_num + NUM_W'(1);
            end
            else
            begin
                res[res_num[SLOT_W-1:0]].out_byte   = data_byte;
                res[res_num[SLOT_W-1:0]].byte_valid = 1'b1;
                res_num = res_num + NUM_W'(1);
            end
        end
        if (last_byte)
        begin
            res[res_num[SLOT_W-1:0]].frame_done = 1'b1;
            res[res_num[SLOT_W-1:0]].status     = code;
            if (code == ST_OK)
            begin
                res[res_num[SLOT_W-1:0]].out_byte     = cfg.end_flag;
                res[res_num[SLOT_W-1:0]].byte_valid   = 1'b1;
                res[res_num[SLOT_W-1:0]].frame_length = len_out;
            end
            res_num = res_num + NUM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            raw_reg        <= '0;
            enc_reg        <= '0;
            perr_reg       <= 1'b0;
            oerr_reg       <= 1'b0;
        end
        else if (accept)
        begin
            frame_open_reg <= !last_byte;
            raw_reg        <= raw_next;
            enc_reg        <= enc_next;
            perr_reg       <= perr_next;
            oerr_reg       <= oerr_next;
        end
    end

endmodule

FILE: design/bsf_out_buf.sv
module bsf_out_buf
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  bsf_pkg::result_t            res [bsf_pkg::MAX_RESULTS],
    input  logic [bsf_pkg::NUM_W-1:0]   res_num,
    output logic                        can_load,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bsf_pkg::result_t            head,
    output logic                        head_last
);
    import bsf_pkg::*;

    result_t            slot_reg [MAX_RESULTS];
    logic [NUM_W-1:0]   left_reg;
    logic [SLOT_W-1:0]  ptr_reg;
    logic               pop;

    assign out_valid = (left_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head_last = (left_reg == NUM_W'(1));
    // take a new burst when empty or when the final word leaves this cycle
    assign can_load  = !out_valid || (head_last && out_ready);
    assign head      = slot_reg[ptr_reg];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot_reg[i] <= res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            ptr_reg  <= '0;
        end
        else if (load)
        begin
            left_reg <= res_num;
            ptr_reg  <= '0;
        end
        else if (pop)
        begin
            left_reg <= left_reg - NUM_W'(1);
            ptr_reg  <= ptr_reg + SLOT_W'(1);
        end
    end

endmodule

FILE: design/byte_stuff_framer_core.sv
// Byte-stuffing frame encoder.
// Input channel (in_valid/in_ready): one raw payload word per handshake,
// data_byte plus last_byte marking the final byte of a frame.
// Output channel (out_valid/out_ready): one encoded word per handshake: start
// flag, payload byte, escape byte, stuffed byte, end flag (with frame_length),
// or a status word (byte_valid low) that closes a frame after an error.
// run_last marks the final word caused by one input word.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write only
// while the block is idle.
// Timing: the first output word is presented in the cycle after the input
// handshake. Throughput: one input word per cycle while each input word
// yields one output word and the receiver is ready; an input word that
// yields several words occupies the output register bank until all have
// left, since the output port moves one word a cycle. The next input word is
// taken in the cycle its predecessor's last word leaves.
// Reset: no frame open, counters and errors cleared, registers at defaults,
// no output pending.
// Receiver stall: pending words hold in the output bank and in_ready drops
// until the bank drains.
module byte_stuff_framer_core
#(
    parameter int COUNT_WIDTH = bsf_pkg::COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_last,
    output logic        frame_done,
    output logic [1:0]  status,
    output logic [15:0] frame_length
);
    import bsf_pkg::*;

    cfg_t               cfg;
    result_t            res [MAX_RESULTS];
    logic [NUM_W-1:0]   res_num;
    logic               accept;
    logic               can_load;
    result_t            head;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_load;
    assign accept    = in_valid && can_load;

    // register file; the user must write it only between frames, the block does not enforce this
    bsf_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // frame state, length checks and word list for the current input word
    bsf_encoder #(.COUNT_WIDTH(COUNT_WIDTH)) u_enc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res       (res),
        .res_num   (res_num)
    );

    // output bank: advance one word per output handshake; an input word
    // that yields no result (inside an errored frame) loads an empty burst
    bsf_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (res),
        .res_num   (res_num),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .head_last (run_last)
    );

    assign out_byte     = head.out_byte;
    assign byte_valid   = head.byte_valid;
    assign frame_done   = head.frame_done;
    assign status       = head.status;
    assign frame_length = head.frame_length;

    // a frame always closes on the final word of its input word
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> run_last)
        else $error("frame_done without run_last");

    // an error status word carries no byte and no length
    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> !byte_valid && (frame_length == 16'd0))
        else $error("error status word carries data");

    // no input word is taken while older words would be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || (run_last && out_ready))
        else $error("input accepted over pending output");

    // words of one burst stay pending: the bank does not empty before its last word
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last && !(in_valid && in_ready) |=> out_valid)
        else $error("output bank lost words");

endmodule
